### rtl/dtsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the disparity tile stream to raster block.
// Depends on nothing; the config registers, tile tracker, pixel mapper and top import it.
package dtsr_pkg;

	// Tile geometry defaults.
	localparam int TILE_SIZE_DEF    = 50;
	localparam int TILE_OVERLAP_DEF = 8;

	// Field widths.
	localparam int WORD_W = 32;
	localparam int TAG_W  = 7;
	localparam int ADDR_W = 12;
	localparam int DISP_W = 7;
	localparam int TILE_W = 6;
	localparam int DIM_W  = 11;
	localparam int CFG_W  = 11;

	// Positions of the fields inside a stream word.
	localparam int TAG_LSB  = 25;
	localparam int ADDR_LSB = 13;
	localparam int DISP_LSB = 5;

	// Address thresholds that classify a drop of the tile address.
	localparam logic [ADDR_W-1:0] WRAP_HIGH      = 12'd2490;
	localparam logic [ADDR_W-1:0] FRAME_ADDR_MIN = 12'd50;
	localparam logic [ADDR_W-1:0] TILE_ADDR_MIN  = 12'd5;
	localparam logic [ADDR_W-1:0] TILE_ADDR_MAX  = 12'd50;

	localparam logic [TILE_W-1:0] TILE_MAX = 6'd63;

	// Register reset values.
	localparam logic [TILE_W-1:0] TILES_PER_ROW_RST = 6'd18;
	localparam logic [DIM_W-1:0]  FRAME_ROWS_RST    = 11'd960;
	localparam logic [DIM_W-1:0]  FRAME_COLS_RST    = 11'd752;
	localparam logic [TAG_W-1:0]  PIXEL_TAG_RST     = 7'd117;

	typedef enum logic [1:0] {
		CFG_TILES_PER_ROW = 2'd0,
		CFG_FRAME_ROWS    = 2'd1,
		CFG_FRAME_COLS    = 2'd2,
		CFG_PIXEL_TAG     = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [TILE_W-1:0] tiles_per_row;
		logic [DIM_W-1:0]  frame_rows;
		logic [DIM_W-1:0]  frame_cols;
		logic [TAG_W-1:0]  pixel_tag;
	} cfg_t;

	// Tile position that applies to the word now in flight.
	typedef struct packed {
		logic              active;
		logic              frame_start;
		logic [TILE_W-1:0] tile_row;
		logic [TILE_W-1:0] tile_col;
	} trk_t;

	typedef struct packed {
		logic              pixel_write;
		logic [DIM_W-1:0]  pixel_row;
		logic [DIM_W-1:0]  pixel_col;
		logic [DISP_W-1:0] disparity;
		logic              frame_start;
	} pixel_t;

endpackage

### rtl/dtsr_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one word of a chosen payload type.
// Depends on nothing; the payload type is given at instantiation.
interface dtsr_stream_if #(
	parameter type payload_t = logic [31:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### rtl/dtsr_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file written through a plain index/data port.
// Depends on dtsr_pkg.
module dtsr_cfg_regs
	import dtsr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tiles_per_row <= TILES_PER_ROW_RST;
			cfg_q.frame_rows    <= FRAME_ROWS_RST;
			cfg_q.frame_cols    <= FRAME_COLS_RST;
			cfg_q.pixel_tag     <= PIXEL_TAG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_TILES_PER_ROW: cfg_q.tiles_per_row <= cfg_data[TILE_W-1:0];
				CFG_FRAME_ROWS:    cfg_q.frame_rows    <= cfg_data[DIM_W-1:0];
				CFG_FRAME_COLS:    cfg_q.frame_cols    <= cfg_data[DIM_W-1:0];
				CFG_PIXEL_TAG:     cfg_q.pixel_tag     <= cfg_data[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/dtsr_tile_track.sv
`timescale 1ns / 1ps
// Frame and tile tracking: detects address wrap and keeps the tile position.
// Depends on dtsr_pkg.
module dtsr_tile_track
	import dtsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [TAG_W-1:0]  tag,
	input  logic [ADDR_W-1:0] addr,
	input  cfg_t              cfg,
	output trk_t              trk
);

	logic [ADDR_W-1:0] last_address_q;
	logic              capture_q;
	logic [TILE_W-1:0] tile_col_q;
	logic [TILE_W-1:0] tile_row_q;

	logic              high;
	logic              below;
	logic              frame_wrap;
	logic              tile_wrap;
	logic              capture_d;
	logic              active;
	logic              advance;
	logic [TILE_W:0]   col_inc;
	logic [TILE_W-1:0] col_d;
	logic [TILE_W-1:0] row_d;

	always_comb begin
		high       = last_address_q > WRAP_HIGH;
		below      = addr < last_address_q;
		frame_wrap = high && below && (addr > FRAME_ADDR_MIN);
		tile_wrap  = high && below && (addr > TILE_ADDR_MIN) && (addr < TILE_ADDR_MAX);

		if (frame_wrap) begin
			capture_d = 1'b1;
		end else if (tile_wrap) begin
			capture_d = 1'b0;
		end else begin
			capture_d = capture_q;
		end

		active  = capture_d && (tag == cfg.pixel_tag);
		// A frame wrap restarts at tile 0 and never advances on the same word.
		advance = active && !frame_wrap && high && below;

		trk.active      = active;
		trk.frame_start = active && frame_wrap;
		trk.tile_row    = (active && frame_wrap) ? '0 : tile_row_q;
		trk.tile_col    = (active && frame_wrap) ? '0 : tile_col_q;

		col_inc = {1'b0, tile_col_q} + 7'd1;
		col_d   = trk.tile_col;
		row_d   = trk.tile_row;
		if (advance) begin
			if (col_inc >= {1'b0, cfg.tiles_per_row} || col_inc > {1'b0, TILE_MAX}) begin
				col_d = '0;
				if (tile_row_q != TILE_MAX) begin
					row_d = tile_row_q + 6'd1;
				end
			end else begin
				col_d = col_inc[TILE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_address_q <= '0;
			capture_q      <= 1'b0;
			tile_col_q     <= '0;
			tile_row_q     <= '0;
		end else if (step) begin
			last_address_q <= addr;
			capture_q      <= capture_d;
			tile_col_q     <= col_d;
			tile_row_q     <= row_d;
		end
	end

endmodule

### rtl/dtsr_pixel_map.sv
`timescale 1ns / 1ps
// Maps a tile address and tile position to a cropped frame-buffer position.
// Depends on dtsr_pkg.
module dtsr_pixel_map
	import dtsr_pkg::*;
#(
	parameter int TILE_SIZE    = TILE_SIZE_DEF,
	parameter int TILE_OVERLAP = TILE_OVERLAP_DEF
) (
	input  logic [ADDR_W-1:0] addr,
	input  logic [DISP_W-1:0] disp,
	input  trk_t              trk,
	input  cfg_t              cfg,
	output pixel_t            pix
);

	localparam int STEP   = TILE_SIZE - TILE_OVERLAP;
	localparam int LO     = TILE_OVERLAP / 2;
	localparam int HI     = TILE_SIZE - TILE_OVERLAP / 2;
	// Reciprocal with enough fraction bits to be exact for any 12-bit address.
	localparam int SHIFT  = 20;
	localparam int RECIP  = ((1 << SHIFT) + TILE_SIZE - 1) / TILE_SIZE;
	localparam int PROD_W = ADDR_W + SHIFT - 3;
	localparam int SR_W   = 8;
	localparam int SC_W   = 6;
	localparam int POS_W  = 13;

	logic [PROD_W-1:0] prod;
	logic [SR_W-1:0]   sr;
	logic [ADDR_W-1:0] rem;
	logic [SC_W-1:0]   sc;
	logic [POS_W-1:0]  r;
	logic [POS_W-1:0]  c;
	logic              inside_tile;
	logic              inside_frame;

	always_comb begin
		prod = PROD_W'(addr) * PROD_W'(RECIP);
		sr   = prod[SHIFT +: SR_W];
		rem  = addr - ADDR_W'(ADDR_W'(sr) * ADDR_W'(TILE_SIZE));
		sc   = rem[SC_W-1:0];

		r = POS_W'(sr) + POS_W'(POS_W'(trk.tile_row) * POS_W'(STEP));
		c = POS_W'(sc) + POS_W'(POS_W'(trk.tile_col) * POS_W'(STEP));

		inside_tile = (SR_W'(sc) < SR_W'(HI)) && (sr < SR_W'(HI)) &&
			(SR_W'(sc) >= SR_W'(LO)) && (sr >= SR_W'(LO));
		inside_frame = (r < POS_W'(cfg.frame_rows)) && (c < POS_W'(cfg.frame_cols));

		pix             = '0;
		pix.frame_start = trk.frame_start;
		if (trk.active && inside_tile && inside_frame) begin
			pix.pixel_write = 1'b1;
			pix.pixel_row   = r[DIM_W-1:0];
			pix.pixel_col   = c[DIM_W-1:0];
			pix.disparity   = disp;
		end
	end

endmodule

### rtl/disparity_tile_stream_to_raster_top.sv
`timescale 1ns / 1ps
// Top level of the disparity tile stream to raster converter.
// Depends on dtsr_pkg, dtsr_stream_if, dtsr_cfg_regs, dtsr_tile_track, dtsr_pixel_map.
//
//   channel   dir  payload                                   handshake
//   word_ch   in   stream_word, 32 bits                      valid/ready
//   pixel_ch  out  pixel_write,row,col,disparity,frame_start valid/ready
//   cfg       in   cfg_we, cfg_index (2), cfg_data (11)      write only
//
// A result passes the input register, then the result register; without stalls, one word per cycle.
// A word is held in the input register while the tile tracker and pixel mapper
// work on it; the result register takes it once it is empty or being drained.
// A stall on pixel_ch holds the result register and backs up into word_ch.
// Reset clears the tile state and loads the register defaults; no clearing pass.
module disparity_tile_stream_to_raster_top
	import dtsr_pkg::*;
#(
	parameter int TILE_SIZE    = TILE_SIZE_DEF,
	parameter int TILE_OVERLAP = TILE_OVERLAP_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	dtsr_stream_if.sink      word_ch,
	dtsr_stream_if.source    pixel_ch,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cfg_t              cfg;
	trk_t              trk;
	pixel_t            pix;

	logic [WORD_W-1:0] word_s1;
	logic              valid_s1;
	pixel_t            pix_s2;
	logic              valid_s2;
	logic              advance;

	assign advance       = valid_s1 && (!valid_s2 || pixel_ch.ready);
	assign word_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (word_ch.ready) begin
				valid_s1 <= word_ch.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (pixel_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (word_ch.ready && word_ch.valid) begin
			word_s1 <= word_ch.payload;
		end
		if (advance) begin
			pix_s2 <= pix;
		end
	end

	dtsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dtsr_tile_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tag    (word_s1[TAG_LSB +: TAG_W]),
		.addr   (word_s1[ADDR_LSB +: ADDR_W]),
		.cfg    (cfg),
		.trk    (trk)
	);

	dtsr_pixel_map #(
		.TILE_SIZE    (TILE_SIZE),
		.TILE_OVERLAP (TILE_OVERLAP)
	) u_map (
		.addr (word_s1[ADDR_LSB +: ADDR_W]),
		.disp (word_s1[DISP_LSB +: DISP_W]),
		.trk  (trk),
		.cfg  (cfg),
		.pix  (pix)
	);

	assign pixel_ch.valid   = valid_s2;
	assign pixel_ch.payload = pix_s2;

endmodule
